### src/hires_scanout_colorizer_defines.svh
// Assertion macros for the hi-res scanout colorizer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HIRES_SCANOUT_COLORIZER_DEFINES_SVH
`define HIRES_SCANOUT_COLORIZER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HSC_ASSERT_NOW(lbl, ante, cons)
`define HSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/hsc_pkg.sv
// Shared types, constants and the page offset function of the colorizer.
// No dependencies.
`default_nettype none
package hsc_pkg;
  localparam int NUM_LANES      = 7;
  localparam int BYTES_PER_LINE = 40;
  localparam int FULL_LINES     = 192;
  localparam int MIXED_LINES    = 160;

  localparam logic CFG_MONO  = 1'b0;
  localparam logic CFG_MIXED = 1'b1;

  localparam logic [5:0] LAST_COLUMN = 6'(BYTES_PER_LINE - 1);
  localparam logic [8:0] FULL_END    = 9'(FULL_LINES);
  localparam logic [8:0] MIXED_END   = 9'(MIXED_LINES);

  typedef logic [23:0] pixel_t;

  localparam pixel_t WHITE_RGB = 24'hFFFFFF;
  localparam pixel_t BLACK_RGB = 24'h000000;
  localparam pixel_t PALETTE [4] = '{24'hFF44FD, 24'h14F53C, 24'h14CFFD, 24'hFF6A3C};

  typedef struct packed {
    logic mono;
    logic sel;
  } lane_ctl_t;

  typedef struct packed {
    logic [7:0]  line;
    logic [5:0]  column;
    logic [12:0] next_offset;
    logic        frame_end;
  } scan_t;

  function automatic logic [12:0] page_offset(input logic [7:0] line, input logic [5:0] col);
    logic [12:0] third;
    third = {6'd0, line[7:6], 5'd0} + {8'd0, line[7:6], 3'd0};
    return {line[2:0], 10'd0} + {3'd0, line[5:3], 7'd0} + third + {7'd0, col};
  endfunction
endpackage
`default_nettype wire

### src/hsc_lane.sv
// One pixel lane: picks the color of one pixel bit.
// Depends on hsc_pkg.
`default_nettype none
module hsc_lane (
  input  hsc_pkg::lane_ctl_t ctl,
  input  logic               pix_bit,
  input  logic               prev_bit,
  input  logic               phase,
  output hsc_pkg::pixel_t    rgb
);
  import hsc_pkg::*;

  always_comb begin
    if (ctl.mono) begin
      rgb = pix_bit ? WHITE_RGB : BLACK_RGB;
    end else if (!pix_bit) begin
      rgb = BLACK_RGB;
    end else if (prev_bit) begin
      rgb = WHITE_RGB;
    end else begin
      rgb = PALETTE[{ctl.sel, phase}];
    end
  end
endmodule
`default_nettype wire

### src/hsc_scan_ctr.sv
// Line and column counters, color history and next page offset.
// Depends on hsc_pkg.
`default_nettype none
module hsc_scan_ctr (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          restart,
  input  logic          mixed,
  input  logic          last_bit,
  output logic          phase_start,
  output logic          prev_start,
  output hsc_pkg::scan_t scan
);
  import hsc_pkg::*;

  logic [7:0] line_r, line_nxt, line_eff;
  logic [5:0] col_r, col_nxt, col_eff;
  logic       phase_r, phase_nxt;
  logic       prev_r, prev_nxt;
  logic       last_col, last_line, line_start;
  logic [8:0] frame_lines;

  always_comb begin
    line_eff    = restart ? 8'd0 : line_r;
    col_eff     = restart ? 6'd0 : col_r;
    line_start  = (col_eff == 6'd0);
    phase_start = line_start ? 1'b0 : phase_r;
    prev_start  = line_start ? 1'b0 : prev_r;
    frame_lines = mixed ? MIXED_END : FULL_END;
    last_col    = (col_eff >= LAST_COLUMN);
    last_line   = (({1'b0, line_eff} + 9'd1) >= frame_lines);
    if (last_col) begin
      col_nxt  = 6'd0;
      line_nxt = last_line ? 8'd0 : line_eff + 8'd1;
    end else begin
      col_nxt  = col_eff + 6'd1;
      line_nxt = line_eff;
    end
    phase_nxt        = ~phase_start;
    prev_nxt         = last_bit;
    scan.line        = line_eff;
    scan.column      = col_eff;
    scan.next_offset = page_offset(line_nxt, col_nxt);
    scan.frame_end   = last_col && last_line;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= 8'd0;
      col_r   <= 6'd0;
      phase_r <= 1'b0;
      prev_r  <= 1'b0;
    end else if (accept) begin
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
    end
  end
endmodule
`default_nettype wire

### src/hsc_merge.sv
// Output stage: gathers the lane colors and scan position into one register.
// Depends on hsc_pkg.
`default_nettype none
module hsc_merge (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  hsc_pkg::pixel_t [hsc_pkg::NUM_LANES-1:0] lane_rgb,
  input  hsc_pkg::scan_t                           scan,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output hsc_pkg::pixel_t [hsc_pkg::NUM_LANES-1:0] out_rgb,
  output hsc_pkg::scan_t                           out_scan
);
  import hsc_pkg::*;

  logic                       valid_r;
  pixel_t [NUM_LANES-1:0]     rgb_r;
  scan_t                      scan_r;
  logic                       load;

  assign in_stall  = valid_r && out_stall;
  assign load      = in_valid && !in_stall;
  assign out_valid = valid_r;
  assign out_rgb   = rgb_r;
  assign out_scan  = scan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rgb_r  <= lane_rgb;
      scan_r <= scan;
    end
  end
endmodule
`default_nettype wire

### src/hires_scanout_colorizer.sv
// Top level of the hi-res scanout colorizer: config registers, seven lanes, output stage.
// Depends on hsc_pkg, hsc_lane, hsc_scan_ctr, hsc_merge and the defines header.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_video_byte, in_restart
//   out      output     out_valid/out_stall pixels 0..6, line, column, offset, frame_end
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// One request per cycle while in_stall is low; each result appears in the cycle after its request is taken.
// All seven pixels are produced at once by the lanes.
// A stalled result holds the output register and stalls the input only while it waits.
// Synchronous reset clears the counters, color history, config and the output valid.
`default_nettype none
`include "hires_scanout_colorizer_defines.svh"
module hires_scanout_colorizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_video_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_pixel_0,
  output logic [23:0] out_pixel_1,
  output logic [23:0] out_pixel_2,
  output logic [23:0] out_pixel_3,
  output logic [23:0] out_pixel_4,
  output logic [23:0] out_pixel_5,
  output logic [23:0] out_pixel_6,
  output logic [7:0]  out_screen_line,
  output logic [5:0]  out_byte_column,
  output logic [12:0] out_next_offset,
  output logic        out_frame_end,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import hsc_pkg::*;

  logic                   mono_r, mixed_r;
  logic                   accept;
  logic                   phase_start, prev_start;
  scan_t                  scan, out_scan;
  lane_ctl_t              ctl;
  pixel_t [NUM_LANES-1:0] lane_rgb, out_rgb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r  <= 1'b0;
      mixed_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MONO:  mono_r  <= cfg_data;
        CFG_MIXED: mixed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && !in_stall;
  assign ctl.mono = mono_r;
  assign ctl.sel  = in_video_byte[7];

  hsc_scan_ctr u_ctr (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .restart     (in_restart),
    .mixed       (mixed_r),
    .last_bit    (in_video_byte[NUM_LANES-1]),
    .phase_start (phase_start),
    .prev_start  (prev_start),
    .scan        (scan)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    localparam logic ODD = 1'(g % 2);
    logic prev_bit;
    if (g == 0) begin : g_first
      assign prev_bit = prev_start;
    end else begin : g_rest
      assign prev_bit = in_video_byte[g-1];
    end
    hsc_lane u_lane (
      .ctl      (ctl),
      .pix_bit  (in_video_byte[g]),
      .prev_bit (prev_bit),
      .phase    (phase_start ^ ODD),
      .rgb      (lane_rgb[g])
    );
  end

  hsc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .lane_rgb  (lane_rgb),
    .scan      (scan),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rgb   (out_rgb),
    .out_scan  (out_scan)
  );

  assign out_pixel_0     = out_rgb[0];
  assign out_pixel_1     = out_rgb[1];
  assign out_pixel_2     = out_rgb[2];
  assign out_pixel_3     = out_rgb[3];
  assign out_pixel_4     = out_rgb[4];
  assign out_pixel_5     = out_rgb[5];
  assign out_pixel_6     = out_rgb[6];
  assign out_screen_line = out_scan.line;
  assign out_byte_column = out_scan.column;
  assign out_next_offset = out_scan.next_offset;
  assign out_frame_end   = out_scan.frame_end;

  `HSC_ASSERT_NEXT(a_accept_gives_result, in_valid && !in_stall, out_valid)
  `HSC_ASSERT_NOW(a_column_range, out_valid, out_byte_column <= LAST_COLUMN)
  `HSC_ASSERT_NOW(a_frame_end_offset, out_valid && out_frame_end,
                  out_next_offset == 13'd0 && out_byte_column == LAST_COLUMN)
endmodule
`default_nettype wire
